FILE: rtl/chacha20_stream_cipher_core_defines.svh
// ----------------------------------------------------------------------------
// ChaCha20 core assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during rst.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_CIPHER_CORE_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_CORE_DEFINES_SVH

// Same-cycle implication.
`define CC20_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CC20_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cc20_pkg.sv
// ----------------------------------------------------------------------------
// ChaCha20 core package
// Shared types, state encodings, constants and helpers.
// ----------------------------------------------------------------------------
package cc20_pkg;

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  // Quarter-round rotate amounts, one per step
  localparam int unsigned ROT_A = 16;
  localparam int unsigned ROT_B = 12;
  localparam int unsigned ROT_C = 8;
  localparam int unsigned ROT_D = 7;

  // Single rounds per block (10 double rounds)
  localparam int unsigned CC20_ROUNDS = 20;

  typedef logic [15:0][31:0] cc20_words_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       is_last;
  } cc20_in_t;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       out_last;
  } cc20_out_t;

  typedef enum logic [2:0] {
    REG_KEY0  = 3'd0,
    REG_KEY1  = 3'd1,
    REG_KEY2  = 3'd2,
    REG_KEY3  = 3'd3,
    REG_NONCE_LO = 3'd4,
    REG_NONCE_HI = 3'd5,
    REG_START = 3'd6
  } cc20_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KICK,
    ST_GEN,
    ST_EMIT
  } cc20_state_t;

  typedef enum logic [1:0] {
    BLK_IDLE,
    BLK_ROUND,
    BLK_ADD
  } cc20_blk_state_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

endpackage

FILE: rtl/chacha20_stream_cipher_core.sv
// Each input byte is registered, then XORed into the output register once that
//   register is free. A byte that opens a keystream block first waits for the
//   block generator, a four-lane step unit doing one quarter-round step a cycle.
//   No new byte is taken until the previous one has reached the output register.
// Reset (synchronous, rst high): config, count, pos clear; next byte opens a message.
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher core
// RFC 7539 keystream over raw bytes: one output byte per input byte, XORed
// with the keystream of the current 64-byte block.
// ----------------------------------------------------------------------------
`include "chacha20_stream_cipher_core_defines.svh"

module chacha20_stream_cipher_core
  import cc20_pkg::*;
#(
  parameter int unsigned ROUNDS = CC20_ROUNDS
) (
  input  logic        clk,
  input  logic        rst,

  // byte input channel
  input  logic        plain_valid,
  output logic        plain_stall,
  input  cc20_in_t    plain_data,

  // byte output channel
  output logic        ciph_valid,
  input  logic        ciph_stall,
  output cc20_out_t   ciph_data,

  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; unknown indexes drop.
  // Key and nonce are read live when a block is generated, the start
  // counter only when a message begins.
  // --------------------------------------------------------------------------
  logic [63:0] key_part [4];
  logic [63:0] nonce_low;
  logic [31:0] nonce_high;
  logic [31:0] start_counter;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_part[i] <= '0;
      nonce_low     <= '0;
      nonce_high    <= '0;
      start_counter <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY0:     key_part[0]   <= cfg_data;
        REG_KEY1:     key_part[1]   <= cfg_data;
        REG_KEY2:     key_part[2]   <= cfg_data;
        REG_KEY3:     key_part[3]   <= cfg_data;
        REG_NONCE_LO: nonce_low     <= cfg_data;
        REG_NONCE_HI: nonce_high    <= cfg_data[31:0];
        REG_START:    start_counter <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  cc20_state_t state, state_next;
  logic [5:0]  pos;        // byte position in current block
  logic        msg_start;  // next byte opens a message
  logic [31:0] count;      // counter of the block being (or next) generated
  cc20_in_t    cur;        // byte in flight

  logic        accept;
  logic        emit;
  logic        out_free;
  logic        need_gen;

  logic        blk_start;
  logic        blk_done;
  cc20_words_t blk_words;
  cc20_words_t init;

  logic [31:0] ks_word;
  logic [7:0]  ks_byte;

  assign accept    = plain_valid && !plain_stall;
  assign out_free  = !ciph_valid || !ciph_stall;
  assign need_gen  = msg_start || (pos == 6'd0);
  assign blk_start = (state == ST_KICK);

  // Block input words: constants, key, counter, nonce
  always_comb begin
    init[0] = SIGMA0;
    init[1] = SIGMA1;
    init[2] = SIGMA2;
    init[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2 * i] = key_part[i][31:0];
      init[5 + 2 * i] = key_part[i][63:32];
    end
    init[12] = count;
    init[13] = nonce_low[31:0];
    init[14] = nonce_low[63:32];
    init[15] = nonce_high;
  end

  cc20_block #(
    .ROUNDS (ROUNDS)
  ) u_block (
    .clk   (clk),
    .rst   (rst),
    .start (blk_start),
    .init  (init),
    .done  (blk_done),
    .words (blk_words)
  );

  // Keystream byte p is byte p mod 4 of word p/4, LSB first
  assign ks_word = blk_words[pos[5:2]];
  assign ks_byte = ks_word[{pos[1:0], 3'b000} +: 8];

  // --------------------------------------------------------------------------
  // Sequencer: take a byte, run a block if one is due, then hand the result
  // to the output register once it is free.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    plain_stall = 1'b1;
    emit        = 1'b0;
    case (state)
      ST_IDLE: begin
        plain_stall = 1'b0;
        if (plain_valid) begin
          state_next = need_gen ? ST_KICK : ST_EMIT;
        end
      end
      ST_KICK: state_next = ST_GEN;
      ST_GEN: begin
        if (blk_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      msg_start <= 1'b1;
      count     <= '0;
    end else begin
      if (accept && msg_start) begin
        pos   <= '0;
        count <= start_counter;
      end
      if (state == ST_GEN && blk_done) begin
        count <= count + 32'd1;
      end
      if (emit) begin
        pos       <= cur.is_last ? 6'd0 : pos + 6'd1;
        msg_start <= cur.is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= plain_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ciph_valid <= 1'b0;
    end else if (emit) begin
      ciph_valid <= 1'b1;
    end else if (!ciph_stall) begin
      ciph_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ciph_data.cipher_byte <= cur.plain_byte ^ ks_byte;
      ciph_data.out_last    <= cur.is_last;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CC20_ASSERT_IMP(a_done_in_gen, blk_done, state == ST_GEN,
    "block finished outside of generation")
  `CC20_ASSERT_NXT(a_kick_gen, state == ST_KICK, state == ST_GEN,
    "block start not followed by generation")
  `CC20_ASSERT_NXT(a_emit_out, emit, ciph_valid && state == ST_IDLE,
    "emitted byte did not reach output register")
  `CC20_ASSERT_NXT(a_last_rewind, emit && cur.is_last, pos == 6'd0 && msg_start,
    "message end did not rewind block position")

endmodule

FILE: rtl/cc20_qr_lane.sv
// ----------------------------------------------------------------------------
// ChaCha20 quarter-round step lane
// One add, xor and rotate: sum = x + y, mix = rotl(z ^ sum, step amount).
// ----------------------------------------------------------------------------
module cc20_qr_lane
  import cc20_pkg::*;
(
  input  logic [31:0] x,
  input  logic [31:0] y,
  input  logic [31:0] z,
  input  logic [1:0]  step,
  output logic [31:0] sum,
  output logic [31:0] mix
);

  logic [31:0] t;

  always_comb begin
    sum = x + y;
    t   = z ^ sum;
    case (step)
      2'd0:    mix = rotl32(t, ROT_A);
      2'd1:    mix = rotl32(t, ROT_B);
      2'd2:    mix = rotl32(t, ROT_C);
      default: mix = rotl32(t, ROT_D);
    endcase
  end

endmodule

FILE: rtl/cc20_block.sv
// ----------------------------------------------------------------------------
// ChaCha20 block generator
// Four step lanes run one quarter-round step per cycle on all four columns or
// diagonals, then the same lanes add the input words back row by row.
// ----------------------------------------------------------------------------
module cc20_block
  import cc20_pkg::*;
#(
  parameter int unsigned ROUNDS = CC20_ROUNDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  cc20_words_t init,
  output logic        done,
  output cc20_words_t words
);

  localparam int unsigned RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  cc20_blk_state_t state, state_next;
  logic [1:0]      step;
  logic [RW-1:0]   round;
  logic [1:0]      row;
  cc20_words_t     w;

  logic            diag;
  logic [31:0]     sum [4];
  logic [31:0]     mix [4];

  assign diag  = round[0];
  assign words = w;

  // Lanes: lane i works on a = w[i] and the b/c/d words of its column or
  // diagonal. In the add pass lane i adds input row 'row' to w[i].
  for (genvar i = 0; i < 4; i++) begin : g_lane
    localparam int BC = 4 + i;
    localparam int BD = 4 + ((i + 1) % 4);
    localparam int CC = 8 + i;
    localparam int CD = 8 + ((i + 2) % 4);
    localparam int DC = 12 + i;
    localparam int DD = 12 + ((i + 3) % 4);

    logic [31:0] a_w, b_w, c_w, d_w, x, y, z;

    always_comb begin
      a_w = w[i];
      b_w = diag ? w[BD] : w[BC];
      c_w = diag ? w[CD] : w[CC];
      d_w = diag ? w[DD] : w[DC];
      z   = step[0] ? b_w : d_w;
      if (state == BLK_ADD) begin
        x = w[i];
        y = init[{row, 2'(i)}];
      end else begin
        x = step[0] ? c_w : a_w;
        y = step[0] ? d_w : b_w;
      end
    end

    cc20_qr_lane u_lane (
      .x    (x),
      .y    (y),
      .z    (z),
      .step (step),
      .sum  (sum[i]),
      .mix  (mix[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BLK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      BLK_IDLE: begin
        if (start) begin
          state_next = BLK_ROUND;
        end
      end
      BLK_ROUND: begin
        if (step == 2'd3 && round == RW'(ROUNDS - 1)) begin
          state_next = BLK_ADD;
        end
      end
      BLK_ADD: begin
        if (row == 2'd3) begin
          done       = 1'b1;
          state_next = BLK_IDLE;
        end
      end
      default: state_next = BLK_IDLE;
    endcase
  end

  // Step/round/row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= '0;
      round <= '0;
      row   <= '0;
    end else begin
      case (state)
        BLK_IDLE: begin
          step  <= '0;
          round <= '0;
          row   <= '0;
        end
        BLK_ROUND: begin
          step <= step + 2'd1;
          row  <= '0;
          if (step == 2'd3) begin
            round <= round + RW'(1);
          end
        end
        BLK_ADD: row <= row + 2'd1;
        default: row <= '0;
      endcase
    end
  end

  // Working words
  always_ff @(posedge clk) begin
    case (state)
      BLK_IDLE: begin
        if (start) begin
          w <= init;
        end
      end
      BLK_ROUND: begin
        for (int i = 0; i < 4; i++) begin
          if (!step[0]) begin
            w[i] <= sum[i];
            if (diag) w[12 + ((i + 3) % 4)] <= mix[i];
            else      w[12 + i]             <= mix[i];
          end else begin
            if (diag) begin
              w[8 + ((i + 2) % 4)] <= sum[i];
              w[4 + ((i + 1) % 4)] <= mix[i];
            end else begin
              w[8 + i] <= sum[i];
              w[4 + i] <= mix[i];
            end
          end
        end
      end
      BLK_ADD: begin
        // Rows rotate up; finished row drops into the bottom. Once all four rows
        // have been added the rows are back in order.
        for (int i = 0; i < 4; i++) begin
          w[i]      <= w[4 + i];
          w[4 + i]  <= w[8 + i];
          w[8 + i]  <= w[12 + i];
          w[12 + i] <= sum[i];
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher core testbench
// Streams message bytes through the core under random sender gaps and
// receiver stalls. Every output transaction is checked against an in-bench
// keystream predictor, with a short table of known-answer bytes up front.
// ----------------------------------------------------------------------------
module tb
  import cc20_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_BYTES  = 116;
  localparam int unsigned DRAIN_CYCLES = 100;   // longer than a block-opening byte
  localparam int unsigned DIR_ROWS     = 19;

  // Index with no register behind it; writes to it must be dropped.
  localparam logic [2:0] REG_NONE = 3'd7;

  // "expand 32-byte k"
  localparam logic [31:0] EXPAND_W0 = 32'h61707865;
  localparam logic [31:0] EXPAND_W1 = 32'h3320646e;
  localparam logic [31:0] EXPAND_W2 = 32'h79622d32;
  localparam logic [31:0] EXPAND_W3 = 32'h6b206574;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  // One directed transaction: stimulus plus, where typed, the known output byte.
  typedef struct packed {
    logic       typed;
    logic [7:0] want;
    cc20_in_t   stim;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // DUT signals, inputs driven to known values from time zero
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        plain_valid = 1'b0;
  logic        plain_stall;
  cc20_in_t    plain_data = '0;
  logic        ciph_valid;
  logic        ciph_stall = 1'b0;
  cc20_out_t   ciph_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  always #5 clk = ~clk;

  chacha20_stream_cipher_core u_top (
    .clk         (clk),
    .rst         (rst),
    .plain_valid (plain_valid),
    .plain_stall (plain_stall),
    .plain_data  (plain_data),
    .ciph_valid  (ciph_valid),
    .ciph_stall  (ciph_stall),
    .ciph_data   (ciph_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Keystream predictor: shadow registers plus the block/byte position
  // ---------------------------------------------------------------------------
  logic [63:0] key_q [4];
  logic [63:0] nonce_lo_q;
  logic [31:0] nonce_hi_q;
  logic [31:0] start_q;
  cc20_words_t ks_q;
  logic [5:0]  pos_q;
  logic [31:0] ctr_q;
  logic        msg_open_q;   // next byte begins a new message

  cc20_out_t   expected_bytes [$];
  dir_row_t    dir_rows [DIR_ROWS];

  int items = 0, msgs = 0, blocks = 0, writes = 0;
  int checked = 0, errors = 0, cycles = 0;

  // sender burst state
  bit gaps_on = 1'b1;
  int burst_left = 0;

  // receiver stall pattern
  rx_mode_t stall_mode = RX_OPEN;
  int stall_tick = 0, stall_period = 4, stall_duty = 1;

  function automatic logic [31:0] rol(logic [31:0] v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [127:0] quarter_mix(logic [31:0] a, logic [31:0] b,
                                               logic [31:0] c, logic [31:0] d);
    a += b; d = rol(d ^ a, 16);
    c += d; b = rol(b ^ c, 12);
    a += b; d = rol(d ^ a, 8);
    c += d; b = rol(b ^ c, 7);
    return {a, b, c, d};
  endfunction

  // 20 rounds over the state built from the current key/nonce, then feed-forward
  function automatic cc20_words_t keystream_block(logic [31:0] counter);
    logic [31:0] init [16];
    logic [31:0] w [16];
    cc20_words_t ks;
    init[0] = EXPAND_W0;
    init[1] = EXPAND_W1;
    init[2] = EXPAND_W2;
    init[3] = EXPAND_W3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2 * i] = key_q[i][31:0];
      init[5 + 2 * i] = key_q[i][63:32];
    end
    init[12] = counter;
    init[13] = nonce_lo_q[31:0];
    init[14] = nonce_lo_q[63:32];
    init[15] = nonce_hi_q;
    w = init;
    for (int r = 0; r < 10; r++) begin
      {w[0], w[4], w[8],  w[12]} = quarter_mix(w[0], w[4], w[8],  w[12]);
      {w[1], w[5], w[9],  w[13]} = quarter_mix(w[1], w[5], w[9],  w[13]);
      {w[2], w[6], w[10], w[14]} = quarter_mix(w[2], w[6], w[10], w[14]);
      {w[3], w[7], w[11], w[15]} = quarter_mix(w[3], w[7], w[11], w[15]);
      {w[0], w[5], w[10], w[15]} = quarter_mix(w[0], w[5], w[10], w[15]);
      {w[1], w[6], w[11], w[12]} = quarter_mix(w[1], w[6], w[11], w[12]);
      {w[2], w[7], w[8],  w[13]} = quarter_mix(w[2], w[7], w[8],  w[13]);
      {w[3], w[4], w[9],  w[14]} = quarter_mix(w[3], w[4], w[9],  w[14]);
    end
    for (int i = 0; i < 16; i++) ks[i] = w[i] + init[i];
    return ks;
  endfunction

  // Advances the predictor by one byte and returns the output it should cause.
  function automatic cc20_out_t cipher_next(cc20_in_t din);
    cc20_out_t res;
    if (msg_open_q) begin
      ctr_q = start_q;   // start counter only matters at message start
      pos_q = '0;
      msg_open_q = 1'b0;
    end
    if (pos_q == 6'd0) begin
      ks_q = keystream_block(ctr_q);   // key/nonce taken per block
      ctr_q = ctr_q + 32'd1;           // wraps mod 2^32
      blocks++;
    end
    res.cipher_byte = din.plain_byte ^ ks_q[pos_q[5:2]][8 * pos_q[1:0] +: 8];
    res.out_last = din.is_last;
    pos_q = pos_q + 6'd1;
    if (din.is_last) begin
      pos_q = '0;        // rest of a short block is dropped
      msg_open_q = 1'b1;
    end
    return res;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [63:0] val);
    case (idx)
      REG_KEY0:     key_q[0] = val;
      REG_KEY1:     key_q[1] = val;
      REG_KEY2:     key_q[2] = val;
      REG_KEY3:     key_q[3] = val;
      REG_NONCE_LO: nonce_lo_q = val;
      REG_NONCE_HI: nonce_hi_q = val[31:0];
      REG_START:    start_q = val[31:0];
      default: ;
    endcase
  endfunction

  function automatic dir_row_t mk(logic t, logic [7:0] w, logic [7:0] p, logic l);
    dir_row_t row;
    row.typed = t;
    row.want = w;
    row.stim.plain_byte = p;
    row.stim.is_last = l;
    return row;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly short messages, some around one block, a few spanning two or three.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 20);
    if (r < 85) return $urandom_range(21, 70);
    return $urandom_range(100, 140);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: everything changes on the falling edge
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One byte transaction. Bursts of random length with random gaps between;
  // valid stays high across back-to-back bytes.
  task automatic send_byte(cc20_in_t din, logic typed, cc20_out_t want);
    cc20_out_t pred;
    int gap;
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 9);
      end
      burst_left--;
    end
    if (gap > 0) begin
      @(negedge clk);
      plain_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    plain_valid <= 1'b1;
    plain_data  <= din;
    do @(posedge clk); while (plain_stall);
    // Predictor runs on every accepted byte; typed rows override its answer.
    pred = cipher_next(din);
    expected_bytes.push_back(typed ? want : pred);
    items++;
    if (din.is_last) msgs++;
  endtask

  task automatic sender_idle();
    @(negedge clk);
    plain_valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // Register settings per phase. The first two hit the extremes; later ones
  // rewrite a random subset, often while a message is still open, so a new
  // key or nonce lands on the next block and a new start counter waits for
  // the next message.
  task automatic set_phase_regs(int p);
    logic [63:0] val;
    case (p)
      0: begin
        write_reg(REG_NONE, '1);
        write_reg(REG_KEY0, '1);
        write_reg(REG_KEY1, '1);
        write_reg(REG_KEY2, '1);
        write_reg(REG_KEY3, '1);
        write_reg(REG_NONCE_LO, '1);
        write_reg(REG_NONCE_HI, '1);
        write_reg(REG_START, '1);      // first block uses counter 2^32-1, then wraps
      end
      1: begin
        write_reg(REG_NONE, '0);
        write_reg(REG_KEY0, '0);
        write_reg(REG_KEY1, '0);
        write_reg(REG_KEY2, '0);
        write_reg(REG_KEY3, '0);
        write_reg(REG_NONCE_LO, '0);
        write_reg(REG_NONCE_HI, '0);
        write_reg(REG_START, '0);
      end
      default: begin
        for (int r = REG_KEY0; r <= REG_START; r++) begin
          if ($urandom_range(0, 3) != 0) begin
            val = {$urandom, $urandom};
            if (r == REG_START && $urandom_range(0, 2) == 0)
              val[31:0] = 32'hffff_ffff - $urandom_range(0, 2);
            write_reg(3'(r), val);
          end
        end
        if ($urandom_range(0, 1) == 1) write_reg(REG_NONE, {$urandom, $urandom});
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern switches between open, random and periodic modes
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_tick == 0) begin
      stall_tick   = $urandom_range(50, 400);
      stall_mode   = rx_mode_t'($urandom_range(0, 2));
      stall_period = $urandom_range(3, 12);
      stall_duty   = $urandom_range(1, stall_period - 1);
    end
    stall_tick--;
    case (stall_mode)
      RX_OPEN:   ciph_stall <= 1'b0;
      RX_RANDOM: ciph_stall <= ($urandom_range(0, 3) == 0);
      default:   ciph_stall <= ((stall_tick % stall_period) < stall_duty);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output check: every accepted transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  cc20_out_t head;

  always @(posedge clk) begin
    if (!rst && ciph_valid && !ciph_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("output byte %h with nothing expected", ciph_data.cipher_byte);
        errors++;
      end else begin
        head = expected_bytes.pop_front();
        checked++;
        if (ciph_data.cipher_byte !== head.cipher_byte) begin
          $error("cipher_byte: expected %h, got %h", head.cipher_byte,
                 ciph_data.cipher_byte);
          errors++;
        end
        if (ciph_data.out_last !== head.out_last) begin
          $error("out_last: expected %b, got %b", head.out_last, ciph_data.out_last);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d outputs still due", cycles,
               expected_bytes.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    cc20_in_t  din;
    cc20_out_t want;
    int len, sent;
    bit first, trunc;

    // predictor reset state
    for (int i = 0; i < 4; i++) key_q[i] = '0;
    nonce_lo_q = '0;
    nonce_hi_q = '0;
    start_q    = '0;
    ks_q       = '0;
    pos_q      = '0;
    ctr_q      = '0;
    msg_open_q = 1'b1;

    // Known answers: all-zero key and nonce, counter 0 keystream starts
    // 76 b8 e0 ad a0 f1 3d 90. Covers mid-block last, one-byte message and
    // restart from the start counter.
    dir_rows = '{
      mk(1'b1, 8'h76, 8'h00, 1'b0),
      mk(1'b1, 8'hb8, 8'h00, 1'b0),
      mk(1'b1, 8'h1f, 8'hff, 1'b0),
      mk(1'b1, 8'had, 8'h00, 1'b0),
      mk(1'b1, 8'h5f, 8'hff, 1'b0),
      mk(1'b1, 8'hf1, 8'h00, 1'b1),   // short last block
      mk(1'b1, 8'h76, 8'h00, 1'b1),   // single-byte message
      mk(1'b1, 8'h89, 8'hff, 1'b0),
      mk(1'b1, 8'hed, 8'h55, 1'b0),
      mk(1'b1, 8'h4a, 8'haa, 1'b0),
      mk(1'b1, 8'hac, 8'h01, 1'b0),
      mk(1'b1, 8'h20, 8'h80, 1'b0),
      mk(1'b1, 8'hf1, 8'h00, 1'b0),
      mk(1'b1, 8'hc2, 8'hff, 1'b0),
      mk(1'b1, 8'hef, 8'h7f, 1'b1),
      mk(1'b0, 8'h00, 8'hc3, 1'b0),
      mk(1'b0, 8'h00, 8'h3c, 1'b0),
      mk(1'b0, 8'h00, 8'h00, 1'b0),
      mk(1'b0, 8'h00, 8'hff, 1'b1)
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      want.cipher_byte = dir_rows[i].want;
      want.out_last    = dir_rows[i].stim.is_last;
      send_byte(dir_rows[i].stim, dir_rows[i].typed, want);
    end
    sender_idle();
    drain();

    // Random phases: registers change only with nothing in flight
    for (int p = 0; p < PHASES; p++) begin
      set_phase_regs(p);
      gaps_on = ($urandom_range(0, 3) != 0);
      trunc   = 1'($urandom_range(0, 1));
      sent    = 0;
      first   = 1'b1;
      while (sent < PHASE_BYTES) begin
        len = (p == 0 && first) ? 100 : pick_len();
        first = 1'b0;
        for (int i = 0; i < len && sent < PHASE_BYTES; i++) begin
          din.plain_byte = pick_byte();
          din.is_last    = (i == len - 1) && !(trunc && sent == PHASE_BYTES - 1);
          send_byte(din, 1'b0, '0);
          sent++;
        end
      end
      sender_idle();
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes over %0d closed messages, %0d keystream blocks, %0d reg writes",
             items, msgs, blocks, writes);
    $display("checked %0d output bytes, %0d mismatches", checked, errors);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/cc20_pkg.sv
rtl/cc20_qr_lane.sv
rtl/cc20_block.sv
rtl/chacha20_stream_cipher_core.sv
bench/tb.sv
